// File: hdl/qlu_pkg.sv
// ----------------------------------------------------------------------------
// qlu_pkg
// Shared types, constants and helpers of the tabular Q-learning update block.
// ----------------------------------------------------------------------------
`default_nettype none

package qlu_pkg;

  // Table geometry
  localparam int NUM_STATES  = 64;
  localparam int NUM_ACTIONS = 4;
  localparam int ROW_W       = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

  // Field widths
  localparam int STATE_W  = 6;
  localparam int ACT_W    = 2;
  localparam int REWARD_W = 16;
  localparam int DRAW_W   = 7;
  localparam int Q_W      = 32;
  localparam int FRAC_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [FRAC_W-1:0] LEARNING_RATE_RST     = 16'd6554;
  localparam logic [FRAC_W-1:0] DISCOUNT_RST          = 16'd58982;
  localparam logic [DRAW_W-1:0] EXPLORE_THRESHOLD_RST = 7'd10;

  typedef logic signed [Q_W-1:0] q_t;
  typedef q_t [NUM_ACTIONS-1:0]  row_t;
  typedef logic [ROW_W-1:0]      row_addr_t;
  typedef logic [ACT_W-1:0]      act_t;

  // One transition
  typedef struct packed {
    logic [STATE_W-1:0]         cur_state;
    logic [ACT_W-1:0]           taken_action;
    logic signed [REWARD_W-1:0] reward;
    logic [STATE_W-1:0]         next_state;
    logic                       learn;
    logic [DRAW_W-1:0]          rand_draw;
    logic [ACT_W-1:0]           rand_action;
  } item_t;

  // One result
  typedef struct packed {
    logic signed [Q_W-1:0] new_value;
    logic [ACT_W-1:0]      next_action;
    logic                  explored;
  } result_t;

  // Configuration register file contents
  typedef struct packed {
    logic [FRAC_W-1:0] learning_rate;
    logic [FRAC_W-1:0] discount;
    logic [DRAW_W-1:0] explore_threshold;
  } cfg_t;

  // Stage strobes from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic read;
    logic mul1;
    logic diff;
    logic mul2;
    logic wb;
    logic finish;
  } ctl_t;

  // Out-of-range state indexes map to the last state
  function automatic row_addr_t clamp_state(logic [STATE_W-1:0] s);
    if (32'(s) >= NUM_STATES) return row_addr_t'(NUM_STATES - 1);
    return row_addr_t'(s);
  endfunction

  // Index of the largest entry of a row, lowest index on ties
  function automatic act_t best_action(row_t r);
    act_t i01;
    act_t i23;
    q_t   v01;
    q_t   v23;
    i01 = ($signed(r[1]) > $signed(r[0])) ? act_t'(1) : act_t'(0);
    i23 = ($signed(r[3]) > $signed(r[2])) ? act_t'(3) : act_t'(2);
    v01 = r[i01];
    v23 = r[i23];
    return ($signed(v23) > $signed(v01)) ? i23 : i01;
  endfunction

endpackage

`default_nettype wire

// File: hdl/qlu_table.sv
// ----------------------------------------------------------------------------
// qlu_table
// Q table storage: one row of all actions per state, one write port and two
// registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module qlu_table
  import qlu_pkg::*;
(
  input  logic      clk,
  input  logic      we,
  input  row_addr_t waddr,
  input  row_t      wdata,
  input  logic      re,
  input  row_addr_t raddr_a,
  input  row_addr_t raddr_b,
  output row_t      rdata_a,
  output row_t      rdata_b
);

  row_t mem [NUM_STATES];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// File: hdl/qlu_update.sv
// ----------------------------------------------------------------------------
// qlu_update
// Update datapath: max of the next row, two registered multiplies, floor
// shifts, saturation, row merge for write back, and the action choice.
// ----------------------------------------------------------------------------
`default_nettype none

module qlu_update
  import qlu_pkg::*;
(
  input  logic      clk,
  input  ctl_t      ctl,
  input  cfg_t      cfg,
  input  item_t     item,
  input  row_t      rd_cur,
  input  row_t      rd_next,
  output logic      learning,
  output row_addr_t wr_addr,
  output row_t      wr_row,
  output result_t   result
);

  localparam int P1_W  = Q_W + FRAC_W + 1;   // discount * max
  localparam int D_W   = Q_W + 3;            // target - q
  localparam int P2_W  = D_W + FRAC_W + 1;   // learning_rate * diff
  localparam int SUM_W = Q_W + 4;

  localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] Q_MIN = -SUM_W'(64'sd2147483648);

  // Latched transition
  row_addr_t                  st_cur;
  row_addr_t                  st_next;
  act_t                       act;
  logic signed [REWARD_W-1:0] reward;
  logic [DRAW_W-1:0]          draw;
  act_t                       ract;

  // Pipeline registers
  row_t                   crow;
  row_t                   nrow;
  q_t                     q;
  q_t                     m;
  q_t                     nv;
  logic signed [P1_W-1:0] prod1;
  logic signed [D_W-1:0]  diff;
  logic signed [P2_W-1:0] prod2;

  logic signed [SUM_W-1:0] sum;
  q_t                      sat_val;
  logic                    pick_rand;

  // Capture transition at accept
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      st_cur   <= clamp_state(item.cur_state);
      st_next  <= clamp_state(item.next_state);
      act      <= item.taken_action;
      reward   <= item.reward;
      learning <= item.learn;
      draw     <= item.rand_draw;
      ract     <= item.rand_action;
    end
  end

  // Sum and saturation of the write-back stage
  always_comb begin
    sum = SUM_W'(q) + SUM_W'(prod2 >>> FRAC_W);
    if (sum > Q_MAX) begin
      sat_val = q_t'(Q_MAX);
    end else if (sum < Q_MIN) begin
      sat_val = q_t'(Q_MIN);
    end else begin
      sat_val = q_t'(sum);
    end
  end

  // Merged row for write back
  always_comb begin
    wr_row      = crow;
    wr_row[act] = sat_val;
  end
  assign wr_addr = st_cur;

  // Arithmetic stages
  always_ff @(posedge clk) begin
    if (ctl.read) begin
      crow <= rd_cur;
      nrow <= rd_next;
      q    <= rd_cur[act];
      nv   <= rd_cur[act];
      m    <= rd_next[best_action(rd_next)];
    end
    if (ctl.mul1) begin
      prod1 <= $signed({1'b0, cfg.discount}) * m;
    end
    if (ctl.diff) begin
      diff <= D_W'($signed({reward, {FRAC_W{1'b0}}})) + D_W'(prod1 >>> FRAC_W) - D_W'(q);
    end
    if (ctl.mul2) begin
      prod2 <= $signed({1'b0, cfg.learning_rate}) * diff;
    end
    if (ctl.wb) begin
      nv <= sat_val;
      // greedy choice sees the updated entry when both states coincide
      if (st_cur == st_next) begin
        nrow[act] <= sat_val;
      end
    end
  end

  // Action choice and result register
  assign pick_rand = learning && (draw <= cfg.explore_threshold);

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      result.new_value   <= nv;
      result.next_action <= pick_rand ? ract : best_action(nrow);
      result.explored    <= pick_rand;
    end
  end

endmodule

`default_nettype wire

// File: hdl/tabular_q_learning_update.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_update
// Tabular Q-learning step: read-modify-write of one Q table entry and the
// choice of the next action, with a configuration register file.
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   --------  ----------------------  ---------------------------------
//   item      start / busy            item   (item_t)
//   result    done strobe, 1 cycle    result (result_t)
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A learning transfer runs from accept to the done strobe through one
// table read, max, two multiply stages with a subtract between, then the
// write back and the action choice. A non-learning transfer skips from max to
// the action choice. The next start is taken in the cycle that done is high.
// After reset a clearing pass zeroes the table, one row a cycle over all
// NUM_STATES rows (64) with busy high; configuration writes are taken throughout.
// The receiver cannot stall: done marks each result for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tabular_q_learning_update
  import qlu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 item,
  output logic                  done,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_MUL1  = 3'd3;
  localparam logic [2:0] ST_DIFF  = 3'd4;
  localparam logic [2:0] ST_MUL2  = 3'd5;
  localparam logic [2:0] ST_WB    = 3'd6;
  localparam logic [2:0] ST_PICK  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  row_addr_t  clr_addr;
  cfg_t       cfg;
  ctl_t       ctl;
  logic       accept;
  logic       learning;

  row_t      rd_cur;
  row_t      rd_next;
  row_t      upd_row;
  row_addr_t upd_addr;
  logic      mem_we;
  row_addr_t mem_waddr;
  row_t      mem_wdata;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learning_rate     <= LEARNING_RATE_RST;
      cfg.discount          <= DISCOUNT_RST;
      cfg.explore_threshold <= EXPLORE_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LEARNING_RATE:     cfg.learning_rate     <= cfg_data;
        CFG_DISCOUNT:          cfg.discount          <= cfg_data;
        CFG_EXPLORE_THRESHOLD: cfg.explore_threshold <= cfg_data[DRAW_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (32'(clr_addr) == NUM_STATES - 1) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_READ;
      ST_READ:  state_next = learning ? ST_MUL1 : ST_PICK;
      ST_MUL1:  state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_WB;
      ST_WB:    state_next = ST_PICK;
      ST_PICK:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_PICK);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + row_addr_t'(1);
      end
    end
  end

  // Stage strobes
  always_comb begin
    ctl.load   = accept;
    ctl.read   = (state == ST_READ);
    ctl.mul1   = (state == ST_MUL1);
    ctl.diff   = (state == ST_DIFF);
    ctl.mul2   = (state == ST_MUL2);
    ctl.wb     = (state == ST_WB);
    ctl.finish = (state == ST_PICK);
  end

  // Write port: clearing pass or write back
  assign mem_we    = (state == ST_CLEAR) || ctl.wb;
  assign mem_waddr = (state == ST_CLEAR) ? clr_addr : upd_addr;
  assign mem_wdata = (state == ST_CLEAR) ? '0 : upd_row;

  qlu_table u_table (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (accept),
    .raddr_a (clamp_state(item.cur_state)),
    .raddr_b (clamp_state(item.next_state)),
    .rdata_a (rd_cur),
    .rdata_b (rd_next)
  );

  qlu_update u_update (
    .clk      (clk),
    .ctl      (ctl),
    .cfg      (cfg),
    .item     (item),
    .rd_cur   (rd_cur),
    .rd_next  (rd_next),
    .learning (learning),
    .wr_addr  (upd_addr),
    .wr_row   (upd_row),
    .result   (result)
  );

endmodule

`default_nettype wire

// File: hdl/qlu_checker.sv
// ----------------------------------------------------------------------------
// qlu_checker
// Port-level checks of the Q-learning block: busy after accept, latency and strobe spacing.
// ----------------------------------------------------------------------------
`default_nettype none

module qlu_checker
  import qlu_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input item_t   item,
  input logic    done,
  input result_t result
);

  // Accepted transfer holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low after accepted transfer");

  // Result strobe is never high back to back
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done high two cycles in a row");

  // Non-learning transfer: done strobe follows accept, result never explored
  a_greedy_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !item.learn |-> ##3 (done && !result.explored))
    else $error("greedy transfer result missing or explored");

  // Learning transfer: done strobe follows accept
  a_learn_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.learn |-> ##7 done)
    else $error("learning transfer result missing");

endmodule

bind tabular_q_learning_update qlu_checker u_qlu_checker (.*);

`default_nettype wire
